/* rtl/core/hci_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI classifier package
// Packet type codes, class codes, event codes and controller interface types.
// ----------------------------------------------------------------------------
package hci_pkg;

	localparam logic [7:0] PT_COMMAND   = 8'h01;
	localparam logic [7:0] PT_ACL       = 8'h02;
	localparam logic [7:0] PT_SCO       = 8'h03;
	localparam logic [7:0] PT_EVENT     = 8'h04;
	localparam logic [7:0] PT_ESCO_LO   = 8'h08;
	localparam logic [7:0] PT_ESCO_HI   = 8'h0B;

	localparam logic [7:0] EV_CONN_DONE = 8'h03;
	localparam logic [7:0] EV_DISCONN   = 8'h05;
	localparam logic [7:0] EV_LE_META   = 8'h3E;
	localparam logic [7:0] LE_ADV_RPT   = 8'h02;

	localparam logic [15:0] HANDLE_MASK = 16'h0FFF;

	localparam logic [3:0] CLS_IGNORED    = 4'd0;
	localparam logic [3:0] CLS_EVENT      = 4'd1;
	localparam logic [3:0] CLS_CONNECT    = 4'd2;
	localparam logic [3:0] CLS_DISCONNECT = 4'd3;
	localparam logic [3:0] CLS_ADVERT     = 4'd4;
	localparam logic [3:0] CLS_ACL        = 4'd5;
	localparam logic [3:0] CLS_SCO        = 4'd6;
	localparam logic [3:0] CLS_ESCO       = 4'd7;
	localparam logic [3:0] CLS_COMMAND    = 4'd8;
	localparam logic [3:0] CLS_OTHER      = 4'd9;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request and classify
		logic scan_start; // zero scan index
		logic scan_step;  // advance scan index
		logic append;     // write new table entry
		logic update;     // write back hit entry
		logic finish;     // latch results into output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_data;    // item needs a table scan
		logic is_connect; // item appends an entry
		logic scan_done;  // scan index reached fill count
		logic match;      // entry at scan index matches
	} dp_stat_t;

endpackage

/* rtl/core/hci_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI classifier datapath
// Header parsing, counters, connection table memory and result register.
// ----------------------------------------------------------------------------
module hci_datapath
	import hci_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256,
	parameter int COUNTER_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  packet_type,
	input  logic [8:0]  packet_length,
	input  logic [63:0] header_low,
	input  logic [15:0] header_high,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [3:0]  packet_class,
	output logic [15:0] link_handle,
	output logic [15:0] payload_length,
	output logic [1:0]  link_kind,
	output logic        entry_hit,
	output logic        table_full,
	output logic [7:0]  entry_slot,
	output logic [31:0] entry_packets,
	output logic [31:0] entry_bytes,
	output logic [31:0] packets_seen,
	output logic [31:0] class_count,
	output logic [31:0] bytes_seen
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = COUNTER_BITS;

	typedef logic [CW-1:0] cnt_t;

	cnt_t cnt_all_q, cnt_ev_q, cnt_acl_q, cnt_sco_q, cnt_esco_q;
	cnt_t cnt_cmd_q, cnt_adv_q, cnt_conn_q, cnt_bytes_q;
	logic [IW:0] used_q;

	logic [15:0] mem_handle [TABLE_ENTRIES];
	logic [CW-1:0] mem_pk [TABLE_ENTRIES];
	logic [CW-1:0] mem_by [TABLE_ENTRIES];

	logic [3:0]  cls_q;
	logic [15:0] handle_q, plen_q;
	logic [1:0]  kind_q;
	logic        data_q, conn_q;
	cnt_t        ccount_q;
	logic [IW:0] idx_q;
	logic        rd_vld_q;
	logic [IW-1:0] rd_idx_q;
	logic [15:0] rd_handle_q;
	logic [CW-1:0] rd_pk_q, rd_by_q;
	logic        hit_q;
	logic        full_q;
	logic [IW-1:0] slot_q;
	logic [CW-1:0] epk_q, eby_q;

	// classification of the incoming request
	logic [7:0] b1, b2, b3, b4, b10;
	logic [3:0] c_cls;
	logic [15:0] c_handle, c_plen;
	logic [1:0] c_kind;
	logic c_data, c_conn;
	logic is_esco;

	always_comb begin
		b1  = header_low[7:0];
		b2  = header_low[15:8];
		b3  = header_low[23:16];
		b4  = header_low[31:24];
		b10 = header_high[15:8];
		is_esco = packet_type >= PT_ESCO_LO && packet_type <= PT_ESCO_HI;
		c_cls = CLS_OTHER;
		c_handle = '0;
		c_plen = '0;
		c_kind = '0;
		c_data = 1'b0;
		c_conn = 1'b0;
		if (packet_length == 9'd0) begin
			c_cls = CLS_IGNORED;
		end else if (packet_type == PT_EVENT) begin
			c_cls = CLS_EVENT;
			if (packet_length > 9'd1) begin
				if (b1 == EV_CONN_DONE && packet_length >= 9'd11) begin
					c_cls = CLS_CONNECT;
					c_handle = {b3, b2};
					c_kind = (b10 >= 8'd1 && b10 <= 8'd3) ? b10[1:0] : 2'd0;
					c_conn = 1'b1;
				end else if (b1 == EV_DISCONN && packet_length >= 9'd4) begin
					c_cls = CLS_DISCONNECT;
					c_handle = {b3, b2};
				end else if (b1 == EV_LE_META && packet_length > 9'd2
						&& b2 == LE_ADV_RPT) begin
					c_cls = CLS_ADVERT;
				end
			end
		end else if (packet_type == PT_ACL) begin
			c_cls = CLS_ACL;
			if (packet_length >= 9'd5) begin
				c_handle = {b2, b1} & HANDLE_MASK;
				c_plen = {b4, b3};
				c_data = 1'b1;
			end
		end else if (packet_type == PT_SCO || is_esco) begin
			c_cls = is_esco ? CLS_ESCO : CLS_SCO;
			if (packet_length >= 9'd4) begin
				c_handle = {b2, b1} & HANDLE_MASK;
				c_plen = {8'd0, b3};
				c_data = 1'b1;
			end
		end else if (packet_type == PT_COMMAND) begin
			c_cls = CLS_COMMAND;
		end
	end

	cnt_t all_n;
	assign all_n = cnt_all_q + cnt_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_all_q <= '0; cnt_ev_q <= '0; cnt_acl_q <= '0; cnt_sco_q <= '0;
			cnt_esco_q <= '0; cnt_cmd_q <= '0; cnt_adv_q <= '0; cnt_conn_q <= '0;
			cnt_bytes_q <= '0;
			used_q <= '0;
		end else begin
			if (cmd.load && packet_length != 9'd0) begin
				cnt_all_q <= all_n;
				if (c_data)
					cnt_bytes_q <= cnt_bytes_q + cnt_t'(c_plen);
				unique case (c_cls)
					CLS_EVENT, CLS_DISCONNECT: cnt_ev_q <= cnt_ev_q + cnt_t'(1);
					CLS_CONNECT: begin
						cnt_ev_q <= cnt_ev_q + cnt_t'(1);
						cnt_conn_q <= cnt_conn_q + cnt_t'(1);
					end
					CLS_ADVERT: begin
						cnt_ev_q <= cnt_ev_q + cnt_t'(1);
						cnt_adv_q <= cnt_adv_q + cnt_t'(1);
					end
					CLS_ACL: cnt_acl_q <= cnt_acl_q + cnt_t'(1);
					CLS_SCO: cnt_sco_q <= cnt_sco_q + cnt_t'(1);
					CLS_ESCO: cnt_esco_q <= cnt_esco_q + cnt_t'(1);
					CLS_COMMAND: cnt_cmd_q <= cnt_cmd_q + cnt_t'(1);
					default: ;
				endcase
			end
			if (cmd.append && used_q < (IW+1)'(TABLE_ENTRIES))
				used_q <= used_q + (IW+1)'(1);
		end
	end

	// request capture; class count after increment; total for disconnect, other, ignored
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cls_q <= c_cls;
			handle_q <= c_handle;
			plen_q <= c_plen;
			kind_q <= c_kind;
			data_q <= c_data;
			conn_q <= c_conn;
			unique case (c_cls)
				CLS_IGNORED: ccount_q <= cnt_all_q;
				CLS_EVENT: ccount_q <= cnt_ev_q + cnt_t'(1);
				CLS_CONNECT: ccount_q <= cnt_conn_q + cnt_t'(1);
				CLS_ADVERT: ccount_q <= cnt_adv_q + cnt_t'(1);
				CLS_ACL: ccount_q <= cnt_acl_q + cnt_t'(1);
				CLS_SCO: ccount_q <= cnt_sco_q + cnt_t'(1);
				CLS_ESCO: ccount_q <= cnt_esco_q + cnt_t'(1);
				CLS_COMMAND: ccount_q <= cnt_cmd_q + cnt_t'(1);
				default: ccount_q <= all_n;
			endcase
		end
	end

	// scan: index issues a read, registered data compared next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= 1'b0;
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_step && idx_q < used_q) begin
				idx_q <= idx_q + (IW+1)'(1);
				rd_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_idx_q <= idx_q[IW-1:0];
			rd_handle_q <= mem_handle[idx_q[IW-1:0]];
			rd_pk_q <= mem_pk[idx_q[IW-1:0]];
			rd_by_q <= mem_by[idx_q[IW-1:0]];
		end
		if (cmd.append && used_q < (IW+1)'(TABLE_ENTRIES)) begin
			mem_handle[used_q[IW-1:0]] <= handle_q;
			mem_pk[used_q[IW-1:0]] <= '0;
			mem_by[used_q[IW-1:0]] <= '0;
		end
		if (cmd.update) begin
			mem_pk[rd_idx_q] <= rd_pk_q + cnt_t'(1);
			mem_by[rd_idx_q] <= rd_by_q + cnt_t'(plen_q);
		end
	end

	assign stat.is_data = data_q;
	assign stat.is_connect = conn_q;
	assign stat.match = rd_vld_q && rd_handle_q == handle_q;
	assign stat.scan_done = !rd_vld_q && idx_q >= used_q;

	// full is judged against the fill count before this append
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit_q <= 1'b0;
			full_q <= 1'b0;
			slot_q <= '0;
			epk_q <= '0;
			eby_q <= '0;
		end
		if (cmd.append) begin
			if (used_q < (IW+1)'(TABLE_ENTRIES)) begin
				hit_q <= 1'b1;
				slot_q <= used_q[IW-1:0];
			end else begin
				full_q <= 1'b1;
			end
		end
		if (cmd.update) begin
			hit_q <= 1'b1;
			slot_q <= rd_idx_q;
			epk_q <= rd_pk_q + cnt_t'(1);
			eby_q <= rd_by_q + cnt_t'(plen_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			packet_class <= cls_q;
			link_handle <= handle_q;
			payload_length <= plen_q;
			link_kind <= kind_q;
			entry_hit <= hit_q;
			table_full <= full_q;
			entry_slot <= 8'(slot_q);
			entry_packets <= 32'(epk_q);
			entry_bytes <= 32'(eby_q);
			packets_seen <= 32'(cnt_all_q);
			class_count <= 32'(ccount_q);
			bytes_seen <= 32'(cnt_bytes_q);
		end
	end

endmodule

/* rtl/core/hci_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI classifier controller
// Sequences request capture, table scan or append, and result delivery.
// ----------------------------------------------------------------------------
module hci_ctrl
	import hci_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_SCAN   = 6'b000100,
		S_UPDATE = 6'b001000,
		S_FINISH = 6'b010000,
		S_WAIT   = 6'b100000
	} state_t;

	state_t state_q;
	logic out_valid_q;

	assign out_valid = out_valid_q;
	// a finished result may sit in the output register while a new request runs
	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_DECIDE: begin
				cmd.scan_start = 1'b1;
				cmd.append = stat.is_connect;
			end
			S_SCAN: cmd.scan_step = !stat.match;
			S_UPDATE: cmd.update = 1'b1;
			S_FINISH: cmd.finish = !out_valid_q || !out_stall;
			S_WAIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FINISH && cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: state_q <= stat.is_data ? S_SCAN : S_FINISH;
				S_SCAN: begin
					if (stat.match) state_q <= S_UPDATE;
					else if (stat.scan_done) state_q <= S_FINISH;
				end
				S_UPDATE: state_q <= S_FINISH;
				S_FINISH: begin
					if (cmd.finish)
						state_q <= S_IDLE;
				end
				S_WAIT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/hci_packet_classifier_link_stats.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI packet classifier with link statistics
// Classifies HCI packet headers, keeps counters and a connection table.
// ----------------------------------------------------------------------------
// One request per packet header, one at a time: the input stalls from accept
// until the result is loaded. Non-data packets go from capture through a
// decide step, where a connect event appends a table entry, to result
// loading. ACL/SCO/eSCO packets scan the connection table one entry per
// cycle through the single memory read port, up to the first match or the
// last of the N entries in use, where N is at most TABLE_ENTRIES. A result
// still stalled at the output holds the next one until it is taken. The
// table needs no clearing after reset.
module hci_packet_classifier_link_stats
	import hci_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256,
	parameter int COUNTER_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  packet_type,
	input  logic [8:0]  packet_length,
	input  logic [63:0] header_low,
	input  logic [15:0] header_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  packet_class,
	output logic [15:0] link_handle,
	output logic [15:0] payload_length,
	output logic [1:0]  link_kind,
	output logic        entry_hit,
	output logic        table_full,
	output logic [7:0]  entry_slot,
	output logic [31:0] entry_packets,
	output logic [31:0] entry_bytes,
	output logic [31:0] packets_seen,
	output logic [31:0] class_count,
	output logic [31:0] bytes_seen
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	hci_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	hci_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES), .COUNTER_BITS(COUNTER_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.packet_type(packet_type), .packet_length(packet_length),
		.header_low(header_low), .header_high(header_high),
		.cmd(cmd), .stat(stat),
		.packet_class(packet_class), .link_handle(link_handle),
		.payload_length(payload_length), .link_kind(link_kind),
		.entry_hit(entry_hit), .table_full(table_full),
		.entry_slot(entry_slot), .entry_packets(entry_packets),
		.entry_bytes(entry_bytes), .packets_seen(packets_seen),
		.class_count(class_count), .bytes_seen(bytes_seen)
	);

endmodule

/* rtl/core/hci_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI classifier port checker
// Port-level properties of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module hci_checker
	import hci_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  packet_class,
	input logic        entry_hit,
	input logic        table_full
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packet_class))
		else $error("result dropped while stalled");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");

	a_hit_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(entry_hit && table_full))
		else $error("hit and full together");

	a_full_connect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> packet_class == CLS_CONNECT)
		else $error("full flag on non-connect");

endmodule

bind hci_packet_classifier_link_stats hci_checker u_hci_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.packet_class(packet_class), .entry_hit(entry_hit), .table_full(table_full)
);
